FILE: rtl/spq_pkg.sv
// Shared types, codes and defaults for the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Default number of entries the queue holds.
  localparam int unsigned DefCapacity = 16;

  // Field widths.
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned FillW   = 5;

  // Command codes carried on in_cmd.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_UNDER = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Operation the controller asks the datapath to carry out.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ENQ,
    OP_DEQ,
    OP_UNDER,
    OP_FULL
  } op_t;

  // Controller state.
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    op_t  op;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/spq_ctrl.sv
// Controller state machine for the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     in_cmd,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          busy,
  output logic          out_valid
);

  state_t state_r, state_nxt;
  logic   cmd_r;
  logic   out_valid_r, out_valid_nxt;

  // State and strobe registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The command of the accepted beat is held until it executes.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs: pick the operation from the held command and the fill status.
  always_comb begin
    cmd.load      = 1'b0;
    cmd.op        = OP_NONE;
    busy          = 1'b0;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_EXEC: begin
        busy          = 1'b1;
        out_valid_nxt = 1'b1;
        if (cmd_r == CMD_ENQ) begin
          cmd.op = stat.full ? OP_FULL : OP_ENQ;
        end else begin
          cmd.op = stat.empty ? OP_UNDER : OP_DEQ;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // The strobe always follows an execute cycle.
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == S_EXEC)
    else $error("result strobe without an execute cycle");

  // A new beat is never taken while one is executing.
  a_no_load_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> !cmd.load)
    else $error("load issued while executing");

  // An operation is issued only in the execute state.
  a_op_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op != OP_NONE |-> state_r == S_EXEC)
    else $error("operation issued outside execute state");

endmodule

`default_nettype wire

FILE: rtl/spq_dp.sv
// Datapath of the stable priority queue: a sorted row of entry cells.
`timescale 1ns / 1ps
`default_nettype none

module spq_dp
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dp_cmd_t                  cmd,
  input  wire logic signed [ValueW-1:0] in_item_value,
  input  wire logic        [PrioW-1:0]  in_item_priority,
  output dp_stat_t                      stat,
  output logic             [1:0]        out_status,
  output logic signed      [ValueW-1:0] out_value,
  output logic             [PrioW-1:0]  out_priority,
  output logic             [FillW-1:0]  out_fill_count
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  logic signed [ValueW-1:0] item_val_r;
  logic        [PrioW-1:0]  item_pri_r;
  logic signed [ValueW-1:0] val_r [CAPACITY];
  logic        [PrioW-1:0]  pri_r [CAPACITY];
  logic        [CountW-1:0] count_r, count_nxt;
  status_t                  status_r;
  logic signed [ValueW-1:0] res_val_r;
  logic        [PrioW-1:0]  res_pri_r;
  logic        [CAPACITY-1:0] at_or_after;

  // Input beat registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_val_r <= in_item_value;
      item_pri_r <= in_item_priority;
    end
  end

  // Each cell is at or past the insert point when it is empty or holds a
  // strictly greater priority; this set is a suffix of the row.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      at_or_after[i] = (CountW'(i) >= count_r) || (pri_r[i] > item_pri_r);
    end
  end

  // Cell row: enqueue shifts the suffix right and drops the new pair at its
  // head; dequeue shifts everything left by one.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                     left_cond;
    logic signed [ValueW-1:0] left_val;
    logic        [PrioW-1:0]  left_pri;
    logic signed [ValueW-1:0] right_val;
    logic        [PrioW-1:0]  right_pri;

    if (g == 0) begin : g_head
      assign left_cond = 1'b0;
      assign left_val  = item_val_r;
      assign left_pri  = item_pri_r;
    end else begin : g_body
      assign left_cond = at_or_after[g-1];
      assign left_val  = val_r[g-1];
      assign left_pri  = pri_r[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_val = val_r[g];
      assign right_pri = pri_r[g];
    end else begin : g_inner
      assign right_val = val_r[g+1];
      assign right_pri = pri_r[g+1];
    end

    always_ff @(posedge clk) begin
      case (cmd.op)
        OP_ENQ: begin
          if (at_or_after[g]) begin
            val_r[g] <= left_cond ? left_val : item_val_r;
            pri_r[g] <= left_cond ? left_pri : item_pri_r;
          end
        end
        OP_DEQ: begin
          val_r[g] <= right_val;
          pri_r[g] <= right_pri;
        end
        default: ;
      endcase
    end
  end

  // Entry count.
  always_comb begin
    count_nxt = count_r;
    case (cmd.op)
      OP_ENQ:  count_nxt = count_r + CountW'(1);
      OP_DEQ:  count_nxt = count_r - CountW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result registers, written in the execute cycle.
  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      res_val_r <= '0;
      res_pri_r <= '0;
      case (cmd.op)
        OP_ENQ:   status_r <= ST_ENQ;
        OP_DEQ: begin
          status_r  <= ST_DEQ;
          res_val_r <= val_r[0];
          res_pri_r <= pri_r[0];
        end
        OP_UNDER: status_r <= ST_UNDER;
        OP_FULL:  status_r <= ST_FULL;
        default:  status_r <= ST_ENQ;
      endcase
    end
  end

  assign stat.full      = (count_r == CountW'(CAPACITY));
  assign stat.empty     = (count_r == '0);
  assign out_status     = status_r;
  assign out_value      = res_val_r;
  assign out_priority   = res_pri_r;
  assign out_fill_count = FillW'(count_r);

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountW'(CAPACITY))
    else $error("entry count above capacity");

  // An accepted enqueue grows the queue by one.
  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_ENQ |=> count_r == $past(count_r) + CountW'(1))
    else $error("enqueue did not add one entry");

  // Refused or underflowing beats leave the queue alone.
  a_refused_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FULL || cmd.op == OP_UNDER) |=> $stable(count_r))
    else $error("refused beat changed the entry count");

  // A dequeue returns the entry that was at the front.
  a_deq_front: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_DEQ |=> res_val_r == $past(val_r[0]) && res_pri_r == $past(pri_r[0]))
    else $error("dequeue did not return the front entry");

endmodule

`default_nettype wire

FILE: rtl/stable_priority_queue.sv
// Top level of the stable priority queue: controller plus cell datapath.
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue of CAPACITY value/priority pairs, kept sorted by
// ascending priority with equal priorities served oldest first. A beat is
// taken when start is high and busy is low; in_cmd selects enqueue or
// dequeue. Every beat gives exactly one result: the taken beat is registered,
// the execute state carries out the compare-and-shift across the cell row,
// then the result is registered onto the out_ ports with out_valid high for
// one cycle. The receiver cannot stall, so it must take the result in that
// cycle. busy is low again while the result is shown, so a new beat can be
// taken then, though never while one executes; in the single execute state
// all cells compare in parallel and shift by one place. An enqueue into a full
// queue is refused with the full status, a dequeue from an empty queue
// reports underflow; out_fill_count is the entry count after the beat,
// kept to its low five bits.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_cmd,
  input  wire logic signed [ValueW-1:0] in_item_value,
  input  wire logic        [PrioW-1:0]  in_item_priority,
  output logic                          out_valid,
  output logic             [1:0]        out_status,
  output logic signed      [ValueW-1:0] out_value,
  output logic             [PrioW-1:0]  out_priority,
  output logic             [FillW-1:0]  out_fill_count
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencing of each beat.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .stat      (dp_stat),
    .cmd       (dp_cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Sorted entry storage and result registers.
  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .stat             (dp_stat),
    .out_status       (out_status),
    .out_value        (out_value),
    .out_priority     (out_priority),
    .out_fill_count   (out_fill_count)
  );

endmodule

`default_nettype wire
